// File: src/synth_voice_allocator_unit_macros.svh
// assertion macros for the voice allocator
// used by the top level only; expects clk and rst_n in scope
`ifndef SYNTH_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_UNIT_MACROS_SVH

// checked outside reset only
`define SVALLOC_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SVALLOC_CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/svalloc_pkg.sv
// shared types and constants for the voice allocator
// no dependencies; used by the cell and the top level
`default_nettype none

package svalloc_pkg;

  localparam int NUM_VOICES = 16;
  localparam int IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int NOTE_W     = 7;
  localparam int STAMP_W    = 32;

  // event kinds
  typedef enum logic {
    OP_NOTE_ON  = 1'b0,
    OP_NOTE_OFF = 1'b1
  } op_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                 free_hit;
    logic [IDX_W-1:0]     free_idx;
    logic                 match_hit;
    logic [IDX_W-1:0]     match_idx;
    logic                 best_hit;
    logic [IDX_W-1:0]     best_idx;
    logic [STAMP_W-1:0]   best_stamp;
    logic [NOTE_W-1:0]    best_note;
  } token_t;

  // voice update broadcast from the controller
  typedef struct packed {
    logic                 en;
    op_t                  op;
    logic [IDX_W-1:0]     idx;
    logic [NOTE_W-1:0]    note;
    logic [STAMP_W-1:0]   stamp;
  } upd_t;

endpackage

`default_nettype wire

// File: src/svalloc_if.sv
// valid/ready channel interfaces: event input, result output, config write
// depends on nothing; payload widths match the allocator fields
`default_nettype none

interface svalloc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [6:0] note_number;

  modport source (output valid, output req_type, output note_number, input ready);
  modport sink   (input valid, input req_type, input note_number, output ready);
endinterface

interface svalloc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] voice_index;
  logic       voice_found;
  logic       voice_stolen;
  logic [6:0] stolen_note;
  logic       percussion_armed;

  modport source (output valid, output voice_index, output voice_found,
                  output voice_stolen, output stolen_note, output percussion_armed,
                  input ready);
  modport sink   (input valid, input voice_index, input voice_found,
                  input voice_stolen, input stolen_note, input percussion_armed,
                  output ready);
endinterface

interface svalloc_cfg_if;
  logic valid;
  logic ready;
  logic percussion_enable;

  modport source (output valid, output percussion_enable, input ready);
  modport sink   (input valid, input percussion_enable, output ready);
endinterface

`default_nettype wire

// File: src/svalloc_cell.sv
// one voice slot: holds active mark, note and stamp, refines the search token
// depends on svalloc_pkg (token_t, upd_t, op_t)
`default_nettype none

module svalloc_cell (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [svalloc_pkg::IDX_W-1:0]     cell_id,
  input  wire logic [svalloc_pkg::NOTE_W-1:0]    ev_note,
  input  wire svalloc_pkg::token_t               tok_in,
  input  wire logic                              tok_vld_in,
  input  wire svalloc_pkg::upd_t                 upd,
  output svalloc_pkg::token_t                    tok_out,
  output logic                                   tok_vld_out
);

  logic                              active_r, active_nxt;
  logic [svalloc_pkg::NOTE_W-1:0]    note_r, note_nxt;
  logic [svalloc_pkg::STAMP_W-1:0]   stamp_r, stamp_nxt;
  svalloc_pkg::token_t               tok_r, tok_nxt;
  logic                              tok_vld_r;

  // fold this voice into the passing token
  always_comb begin
    tok_nxt = tok_in;
    if (!active_r && !tok_in.free_hit) begin
      tok_nxt.free_hit = 1'b1;
      tok_nxt.free_idx = cell_id;
    end
    if (active_r && (note_r == ev_note) && !tok_in.match_hit) begin
      tok_nxt.match_hit = 1'b1;
      tok_nxt.match_idx = cell_id;
    end
    // strict compare keeps the earlier voice on equal stamps
    if (!tok_in.best_hit || (stamp_r < tok_in.best_stamp)) begin
      tok_nxt.best_hit   = 1'b1;
      tok_nxt.best_idx   = cell_id;
      tok_nxt.best_stamp = stamp_r;
      tok_nxt.best_note  = note_r;
    end
  end

  // apply an update addressed to this voice
  always_comb begin
    active_nxt = active_r;
    note_nxt   = note_r;
    stamp_nxt  = stamp_r;
    if (upd.en && (upd.idx == cell_id)) begin
      if (upd.op == svalloc_pkg::OP_NOTE_ON) begin
        active_nxt = 1'b1;
        note_nxt   = upd.note;
        stamp_nxt  = upd.stamp;
      end else begin
        active_nxt = 1'b0;
        note_nxt   = '0;
      end
    end
  end

  // voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      note_r   <= '0;
      stamp_r  <= '0;
    end else begin
      active_r <= active_nxt;
      note_r   <= note_nxt;
      stamp_r  <= stamp_nxt;
    end
  end

  // token stage towards the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_out     = tok_r;
  assign tok_vld_out = tok_vld_r;

endmodule

`default_nettype wire

// File: src/synth_voice_allocator_unit.sv
// Polyphonic voice allocator with oldest-note stealing.
// Channels: in_ch carries note events (req_type 0 note on, 1 note off,
// note_number), out_ch returns one result per event, cfg_ch writes the
// percussion enable bit and is always ready.
// The voices sit in a row of cells. Each accepted event launches a search
// token into the first cell; it moves one cell per cycle and collects the
// first free voice, the first active voice holding the note and the voice
// with the oldest stamp. When it leaves the last cell the controller picks
// the voice, broadcasts the update and loads the result register.
// Result path: go_r, the cell token stages, fin_r, the output register.
// One event at a time: the token must walk the row of cells before the next
// is taken; in_ch.ready is high only between events.
// A result waiting in the output register does not block the next event;
// a stalled receiver holds the following event at its final step until the
// register frees.
// Reset (synchronous, active low) frees every voice, clears stamps, the
// note-on counter and the percussion enable, and empties the output.
// Depends on svalloc_pkg, svalloc_if, svalloc_cell and the macro header.
`default_nettype none
`include "synth_voice_allocator_unit_macros.svh"

module synth_voice_allocator_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  svalloc_in_if.sink  in_ch,
  svalloc_out_if.source out_ch,
  svalloc_cfg_if.sink cfg_ch
);

  localparam int N = svalloc_pkg::NUM_VOICES;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                            state_r, state_nxt;
  logic                              go_r;
  svalloc_pkg::op_t                  ev_op_r;
  logic [svalloc_pkg::NOTE_W-1:0]    ev_note_r;
  logic [svalloc_pkg::STAMP_W-1:0]   seq_r, seq_nxt;
  logic                              perc_r;
  svalloc_pkg::token_t               fin_r;
  svalloc_pkg::upd_t                 upd;

  svalloc_pkg::token_t               tok     [0:N];
  logic [N:0]                        tok_vld;

  logic                              in_xfer;
  logic                              out_free;
  logic                              commit;

  logic                              out_valid_r, out_valid_nxt;
  logic [3:0]                        res_idx_r;
  logic                              res_found_r;
  logic                              res_stolen_r;
  logic [6:0]                        res_old_r;
  logic                              res_perc_r;

  logic [svalloc_pkg::IDX_W-1:0]     pick_idx;
  logic                              pick_found;
  logic                              pick_stolen;
  logic [svalloc_pkg::NOTE_W-1:0]    pick_old;
  logic                              pick_perc;

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perc_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      perc_r <= cfg_ch.percussion_enable;
    end
  end

  // handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign commit      = (state_r == ST_FIN) && out_free;

  // row of voice cells
  assign tok[0]     = '0;
  assign tok_vld[0] = go_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    svalloc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_id     (svalloc_pkg::IDX_W'(i)),
      .ev_note     (ev_note_r),
      .tok_in      (tok[i]),
      .tok_vld_in  (tok_vld[i]),
      .upd         (upd),
      .tok_out     (tok[i+1]),
      .tok_vld_out (tok_vld[i+1])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_vld[N]) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= in_xfer;
    end
  end

  // event capture and final token
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_op_r   <= svalloc_pkg::op_t'(in_ch.req_type);
      ev_note_r <= in_ch.note_number;
    end
    if (tok_vld[N]) begin
      fin_r <= tok[N];
    end
  end

  // choose the voice from the finished search
  always_comb begin
    pick_idx    = '0;
    pick_found  = 1'b0;
    pick_stolen = 1'b0;
    pick_old    = '0;
    pick_perc   = 1'b0;
    if (ev_op_r == svalloc_pkg::OP_NOTE_ON) begin
      pick_found = 1'b1;
      pick_perc  = perc_r;
      if (fin_r.free_hit) begin
        pick_idx = fin_r.free_idx;
      end else begin
        pick_idx    = fin_r.best_idx;
        pick_stolen = 1'b1;
        pick_old    = fin_r.best_note;
      end
    end else if (fin_r.match_hit) begin
      pick_idx   = fin_r.match_idx;
      pick_found = 1'b1;
    end
  end

  // update broadcast to the cells
  always_comb begin
    upd.en    = commit && pick_found;
    upd.op    = ev_op_r;
    upd.idx   = pick_idx;
    upd.note  = ev_note_r;
    upd.stamp = seq_r;
  end

  // note-on counter
  always_comb begin
    seq_nxt = seq_r;
    if (commit && (ev_op_r == svalloc_pkg::OP_NOTE_ON)) begin
      seq_nxt = seq_r + svalloc_pkg::STAMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_idx_r    <= 4'(pick_idx);
      res_found_r  <= pick_found;
      res_stolen_r <= pick_stolen;
      res_old_r    <= pick_old;
      res_perc_r   <= pick_perc;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.voice_index      = res_idx_r;
  assign out_ch.voice_found      = res_found_r;
  assign out_ch.voice_stolen     = res_stolen_r;
  assign out_ch.stolen_note      = res_old_r;
  assign out_ch.percussion_armed = res_perc_r;

  // checks
  `SVALLOC_CHK(a_single_token, $onehot0(tok_vld), "more than one search token in the row")
  `SVALLOC_CHK(a_idle_no_token, in_ch.ready |-> (tok_vld == '0), "token in flight while idle")
  `SVALLOC_CHK(a_steal_found, (out_ch.valid && out_ch.voice_stolen) |-> out_ch.voice_found, "steal without a voice")
  `SVALLOC_CHK_ALWAYS(a_reset_empty, !rst_n |=> !out_ch.valid, "result valid after reset")

endmodule

`default_nettype wire

// File: test/synth_voice_allocator_unit_tb.sv
// self-checking testbench for synth_voice_allocator_unit: note events in, one result out
// depends on svalloc_pkg, the svalloc_if channel interfaces and the allocator rtl
`timescale 1ns / 1ps

module synth_voice_allocator_unit_tb;

  localparam int NV          = svalloc_pkg::NUM_VOICES;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 150;

  // one allocation result as seen on the output channel
  typedef struct packed {
    logic [3:0]                     voice_index;
    logic                           voice_found;
    logic                           voice_stolen;
    logic [svalloc_pkg::NOTE_W-1:0] stolen_note;
    logic                           percussion_armed;
  } alloc_result_t;

  // mirror of the voice table plus the queue of results still owed by the block
  class voice_tracker;
    bit                              voice_on [NV];
    logic [svalloc_pkg::NOTE_W-1:0]  voice_key[NV];
    logic [svalloc_pkg::STAMP_W-1:0] voice_age[NV];
    logic [svalloc_pkg::STAMP_W-1:0] on_count;
    logic                            perc_en;
    alloc_result_t                   awaited_results[$];
    int n_fail, n_checked, n_steals, n_freed, n_missed, n_perc;

    function new();
      for (int v = 0; v < NV; v++) begin
        voice_on[v]  = 1'b0;
        voice_key[v] = '0;
        voice_age[v] = '0;
      end
      on_count = '0;
      perc_en  = 1'b0;
    endfunction

    // pick or free a voice and return the result the block should give
    function alloc_result_t allocate(svalloc_pkg::op_t op, logic [svalloc_pkg::NOTE_W-1:0] note);
      alloc_result_t r;
      int v;
      int pick;
      r    = '0;
      pick = -1;
      if (op == svalloc_pkg::OP_NOTE_ON) begin
        for (v = 0; v < NV; v++)
          if (!voice_on[v] && pick < 0) pick = v;
        // no free voice: take the oldest stamp, lowest index on ties
        if (pick < 0) begin
          pick = 0;
          for (v = 1; v < NV; v++)
            if (voice_age[v] < voice_age[pick]) pick = v;
          r.voice_stolen = 1'b1;
          r.stolen_note  = voice_key[pick];
          n_steals++;
        end
        voice_on[pick]     = 1'b1;
        voice_key[pick]    = note;
        voice_age[pick]    = on_count;
        on_count           = on_count + 1'b1;
        r.percussion_armed = perc_en;
        r.voice_index      = 4'(pick);
        r.voice_found      = 1'b1;
        if (perc_en) n_perc++;
      end else begin
        for (v = 0; v < NV; v++)
          if (voice_on[v] && voice_key[v] == note && pick < 0) pick = v;
        // freed voice keeps its stamp, loses its note
        if (pick >= 0) begin
          voice_on[pick]  = 1'b0;
          voice_key[pick] = '0;
          r.voice_index   = 4'(pick);
          r.voice_found   = 1'b1;
          n_freed++;
        end else begin
          n_missed++;
        end
      end
      return r;
    endfunction

    function void note_input(svalloc_pkg::op_t op, logic [svalloc_pkg::NOTE_W-1:0] note);
      awaited_results.push_back(allocate(op, note));
    endfunction

    function void log_failure(string what, alloc_result_t exp, alloc_result_t got);
      n_fail++;
      if (n_fail <= 10)
        $display({"[%0t] %s: expected idx=%0d found=%b stolen=%b old=%0d perc=%b,",
                  " got idx=%0d found=%b stolen=%b old=%0d perc=%b"},
                 $time, what,
                 exp.voice_index, exp.voice_found, exp.voice_stolen, exp.stolen_note,
                 exp.percussion_armed,
                 got.voice_index, got.voice_found, got.voice_stolen, got.stolen_note,
                 got.percussion_armed);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      bit bad;
      if (awaited_results.size() == 0) begin
        log_failure("result with nothing awaited", '0, got);
        return;
      end
      exp = awaited_results.pop_front();
      n_checked++;
      bad = (got.voice_index      !== exp.voice_index)  ||
            (got.voice_found      !== exp.voice_found)  ||
            (got.voice_stolen     !== exp.voice_stolen) ||
            (got.stolen_note      !== exp.stolen_note)  ||
            (got.percussion_armed !== exp.percussion_armed);
      if (bad) log_failure("result mismatch", exp, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  voice_tracker tracker;
  bit   gaps_enabled;
  bit   receiver_hold_req;
  int   cycle_count;

  svalloc_in_if  in_ch();
  svalloc_out_if out_ch();
  svalloc_cfg_if cfg_ch();

  synth_voice_allocator_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // transfer monitor on all three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        tracker.note_input(svalloc_pkg::op_t'(in_ch.req_type), in_ch.note_number);
      if (out_ch.valid && out_ch.ready)
        tracker.check_result({out_ch.voice_index, out_ch.voice_found, out_ch.voice_stolen,
                              out_ch.stolen_note, out_ch.percussion_armed});
      if (cfg_ch.valid && cfg_ch.ready)
        tracker.perc_en = cfg_ch.percussion_enable;
    end
  end

  // result receiver: random stall bursts, one long hold on request
  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // offer one event, with an optional idle burst first; valid stays high afterwards
  task automatic send_event(svalloc_pkg::op_t op, logic [svalloc_pkg::NOTE_W-1:0] note);
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= op;
    in_ch.note_number <= note;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait until every awaited result has been seen
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.awaited_results.size() != 0);
  endtask

  // register write, only called with the block idle
  task automatic write_percussion(logic en);
    in_ch.valid              <= 1'b0;
    cfg_ch.valid             <= 1'b1;
    cfg_ch.percussion_enable <= en;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed play: note-ons and releases of sounding notes, some stray note-offs
  task automatic random_event(int on_pct, int span);
    int r;
    int v;
    logic [svalloc_pkg::NOTE_W-1:0] playing[$];
    logic [svalloc_pkg::NOTE_W-1:0] note;
    r = $urandom_range(0, 99);
    for (v = 0; v < NV; v++)
      if (tracker.voice_on[v]) playing.push_back(tracker.voice_key[v]);
    if (span >= 127) note = 7'($urandom_range(0, 127));
    else note = 7'(60 + $urandom_range(0, span));
    if (r < on_pct) begin
      send_event(svalloc_pkg::OP_NOTE_ON, note);
    end else if (r < 90 && playing.size() != 0) begin
      send_event(svalloc_pkg::OP_NOTE_OFF, playing[$urandom_range(0, playing.size() - 1)]);
    end else begin
      send_event(svalloc_pkg::OP_NOTE_OFF, note);
    end
  endtask

  initial begin : stimulus
    int i;
    int ph;
    tracker           = new();
    gaps_enabled      = 1'b1;
    receiver_hold_req = 1'b0;
    cycle_count       = 0;
    rst_n             = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.req_type           = 1'b0;
    in_ch.note_number        = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.percussion_enable = 1'b0;

    // reset
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_percussion(1'b0);

    // directed: stray note-off, extremes, duplicate notes, lowest free voice
    send_event(svalloc_pkg::OP_NOTE_OFF, 7'd0);
    send_event(svalloc_pkg::OP_NOTE_ON,  7'd0);
    send_event(svalloc_pkg::OP_NOTE_ON,  7'd127);
    send_event(svalloc_pkg::OP_NOTE_ON,  7'd127);
    send_event(svalloc_pkg::OP_NOTE_OFF, 7'd127);
    send_event(svalloc_pkg::OP_NOTE_ON,  7'd85);
    wait_drained();

    // directed with percussion: fill the table, then steal the two oldest
    write_percussion(1'b1);
    for (i = 0; i < NV - 3; i++)
      send_event(svalloc_pkg::OP_NOTE_ON, 7'(i * 9 + 42));
    send_event(svalloc_pkg::OP_NOTE_ON,  7'd42);
    send_event(svalloc_pkg::OP_NOTE_ON,  7'h55);
    send_event(svalloc_pkg::OP_NOTE_OFF, 7'd127);
    send_event(svalloc_pkg::OP_NOTE_OFF, 7'h2A);
    wait_drained();

    // random phases, both percussion settings, no gaps in the last one
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_percussion(ph[0]);
      if (ph == PHASES - 1) gaps_enabled = 1'b0;
      if (ph == 4) receiver_hold_req = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++)
        random_event($urandom_range(45, 70), (ph % 3 == 0) ? 127 : $urandom_range(4, 20));
    end

    // drain and let any stray result show up
    wait_drained();
    repeat (NV + 4) @(posedge clk);
    tracker.n_fail += tracker.awaited_results.size();

    $display("checked %0d results: %0d steals, %0d voices freed, %0d unmatched note-offs",
             tracker.n_checked, tracker.n_steals, tracker.n_freed, tracker.n_missed);
    $display("%0d note-ons with percussion armed, %0d failures", tracker.n_perc, tracker.n_fail);
    if (tracker.n_fail == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
